FILE: rtl/core/owbm_pkg.sv
// Package for the one-wire bus master: action, phase and register index codes,
// timing register and word types, and the default timing values.
// No dependencies; owbm_csr, owbm_engine and the top level import it.
package owbm_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int READ_BITS_DEFAULT  = 16;
   localparam int WRITE_BITS_DEFAULT = 8;
   localparam int SIGN_BIT_DEFAULT   = 12;

   localparam logic [9:0] RESET_LOW_DEFAULT       = 10'd480;
   localparam logic [9:0] PRESENCE_SAMPLE_DEFAULT = 10'd70;
   localparam logic [9:0] RESET_TAIL_DEFAULT      = 10'd410;
   localparam logic [7:0] ONE_LOW_DEFAULT         = 8'd6;
   localparam logic [7:0] ZERO_LOW_DEFAULT        = 8'd60;
   localparam logic [7:0] WRITE_SLOT_DEFAULT      = 8'd70;
   localparam logic [7:0] READ_SAMPLE_DEFAULT     = 8'd15;
   localparam logic [7:0] READ_SLOT_DEFAULT       = 8'd70;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_RESET = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_READ  = 2'd3
   } act_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_RLOW  = 3'd1,
      PH_RREL  = 3'd2,
      PH_RTAIL = 3'd3,
      PH_WRITE = 3'd4,
      PH_READ  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      REG_RESET_LOW       = 3'd0,
      REG_PRESENCE_SAMPLE = 3'd1,
      REG_RESET_TAIL      = 3'd2,
      REG_ONE_LOW         = 3'd3,
      REG_ZERO_LOW        = 3'd4,
      REG_WRITE_SLOT      = 3'd5,
      REG_READ_SAMPLE     = 3'd6,
      REG_READ_SLOT       = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [9:0] reset_low;
      logic [9:0] presence_sample;
      logic [9:0] reset_tail;
      logic [7:0] one_low;
      logic [7:0] zero_low;
      logic [7:0] write_slot;
      logic [7:0] read_sample;
      logic [7:0] read_slot;
   } timing_type;

   typedef struct packed {
      act_type    action;
      logic [7:0] write_byte;
      logic       line_level;
   } item_type;

   typedef struct packed {
      logic        drive_low;
      logic        busy_res;
      logic        done_res;
      logic        presence;
      logic [15:0] read_word;
      logic        sign_set;
      logic        rejected;
   } result_type;

endpackage

FILE: rtl/core/owbm_req_if.sv
// Request channel of the one-wire bus master: valid/ready handshake and the
// action, write byte and sampled line level of one word. No dependencies.
interface owbm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] write_byte;
   logic       line_level;

   modport source (output valid, output action, output write_byte, output line_level,
                   input ready);
   modport sink   (input valid, input action, input write_byte, input line_level,
                   output ready);
endinterface

FILE: rtl/core/owbm_rsp_if.sv
// Response channel of the one-wire bus master: valid/ready handshake and the
// drive, status and read data of one word. No dependencies.
interface owbm_rsp_if;
   logic        valid;
   logic        ready;
   logic        drive_low;
   logic        busy_res;
   logic        done_res;
   logic        presence;
   logic [15:0] read_word;
   logic        sign_set;
   logic        rejected;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output presence, output read_word, output sign_set, output rejected,
                   input ready);
   modport sink   (input valid, input drive_low, input busy_res, input done_res,
                   input presence, input read_word, input sign_set, input rejected,
                   output ready);
endinterface

FILE: rtl/core/owbm_csr.sv
// Timing register file of the one-wire bus master behind an APB-style port.
// Depends on owbm_pkg for the register index codes and the timing struct.
module owbm_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [owbm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [owbm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [owbm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output owbm_pkg::timing_type           timing
);
   import owbm_pkg::*;

   timing_type    timing_ff;
   timing_type    timing_in;
   reg_index_type index;
   logic          wr_en;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign timing     = timing_ff;

   always_comb begin
      timing_in = timing_ff;
      if (wr_en) begin
         unique case (index)
            REG_RESET_LOW:       timing_in.reset_low       = csr_pwdata[9:0];
            REG_PRESENCE_SAMPLE: timing_in.presence_sample = csr_pwdata[9:0];
            REG_RESET_TAIL:      timing_in.reset_tail      = csr_pwdata[9:0];
            REG_ONE_LOW:         timing_in.one_low         = csr_pwdata[7:0];
            REG_ZERO_LOW:        timing_in.zero_low        = csr_pwdata[7:0];
            REG_WRITE_SLOT:      timing_in.write_slot      = csr_pwdata[7:0];
            REG_READ_SAMPLE:     timing_in.read_sample     = csr_pwdata[7:0];
            REG_READ_SLOT:       timing_in.read_slot       = csr_pwdata[7:0];
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_RESET_LOW:       csr_prdata = CSR_DATA_W'(timing_ff.reset_low);
         REG_PRESENCE_SAMPLE: csr_prdata = CSR_DATA_W'(timing_ff.presence_sample);
         REG_RESET_TAIL:      csr_prdata = CSR_DATA_W'(timing_ff.reset_tail);
         REG_ONE_LOW:         csr_prdata = CSR_DATA_W'(timing_ff.one_low);
         REG_ZERO_LOW:        csr_prdata = CSR_DATA_W'(timing_ff.zero_low);
         REG_WRITE_SLOT:      csr_prdata = CSR_DATA_W'(timing_ff.write_slot);
         REG_READ_SAMPLE:     csr_prdata = CSR_DATA_W'(timing_ff.read_sample);
         REG_READ_SLOT:       csr_prdata = CSR_DATA_W'(timing_ff.read_slot);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.reset_low       <= RESET_LOW_DEFAULT;
         timing_ff.presence_sample <= PRESENCE_SAMPLE_DEFAULT;
         timing_ff.reset_tail      <= RESET_TAIL_DEFAULT;
         timing_ff.one_low         <= ONE_LOW_DEFAULT;
         timing_ff.zero_low        <= ZERO_LOW_DEFAULT;
         timing_ff.write_slot      <= WRITE_SLOT_DEFAULT;
         timing_ff.read_sample     <= READ_SAMPLE_DEFAULT;
         timing_ff.read_slot       <= READ_SLOT_DEFAULT;
      end else begin
         timing_ff <= timing_in;
      end
   end

endmodule

FILE: rtl/core/owbm_engine.sv
// Bus master sequencer: phase machine, slot and bit counters, shift registers
// and the result register. Depends on owbm_pkg.
module owbm_engine #(
   parameter int READ_BITS  = owbm_pkg::READ_BITS_DEFAULT,
   parameter int WRITE_BITS = owbm_pkg::WRITE_BITS_DEFAULT,
   parameter int SIGN_BIT   = owbm_pkg::SIGN_BIT_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  owbm_pkg::timing_type timing,
   input  logic                 item_valid,
   input  owbm_pkg::item_type   item,
   output logic                 take,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output owbm_pkg::result_type result
);
   import owbm_pkg::*;

   localparam int MAX_BITS = (READ_BITS > WRITE_BITS) ? READ_BITS : WRITE_BITS;
   localparam int BW       = $clog2(MAX_BITS + 1);

   phase_type             phase_ff, phase_in;
   logic [9:0]            slot_ff, slot_in;
   logic [BW-1:0]         bit_ff, bit_in;
   logic [WRITE_BITS-1:0] out_shift_ff, out_shift_in;
   logic [READ_BITS-1:0]  in_shift_ff, in_shift_in;
   logic                  presence_ff, presence_in;
   logic                  sign_ff, sign_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            result_ff, result_in;

   logic          fire, is_start, busy;
   logic [9:0]    cnt_inc;
   logic [BW-1:0] bit_inc;
   logic          rlow_end, rrel_end, rtail_end, wslot_end, rslot_end, rsample;
   logic          last_wbit, last_rbit;
   logic          drive, done, rejected;
   logic [63:0]   in_wide;

   // Level the line gets on the next tick for a given state.
   function automatic logic drive_level(phase_type ph, logic [9:0] cnt, logic lsb,
                                        timing_type t);
      logic [10:0] k;
      logic [7:0]  low;
      begin
         k   = {1'b0, cnt} + 11'd1;
         low = lsb ? t.one_low : t.zero_low;
         unique case (ph)
            PH_RLOW:  drive_level = 1'b1;
            PH_WRITE: drive_level = (k <= {3'b000, low});
            PH_READ:  drive_level = (k <= {3'b000, t.one_low});
            default:  drive_level = 1'b0;
         endcase
      end
   endfunction

   assign take     = !rsp_valid_ff || rsp_ready;
   assign fire     = item_valid && take;
   assign is_start = item.action != ACT_TICK;
   assign busy     = phase_ff != PH_IDLE;

   assign cnt_inc   = slot_ff + 10'd1;
   assign bit_inc   = bit_ff + BW'(1);
   assign rlow_end  = cnt_inc >= timing.reset_low;
   assign rrel_end  = cnt_inc >= timing.presence_sample;
   assign rtail_end = cnt_inc >= timing.reset_tail;
   assign wslot_end = cnt_inc >= {2'b00, timing.write_slot};
   assign rslot_end = cnt_inc >= {2'b00, timing.read_slot};
   assign rsample   = cnt_inc == {2'b00, timing.read_sample};
   assign last_wbit = bit_inc >= BW'(WRITE_BITS);
   assign last_rbit = bit_inc >= BW'(READ_BITS);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (is_start) begin
         if (!busy) begin
            unique case (item.action)
               ACT_RESET: phase_in = PH_RLOW;
               ACT_WRITE: phase_in = PH_WRITE;
               ACT_READ:  phase_in = PH_READ;
               default:   phase_in = phase_ff;
            endcase
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE:  phase_in = PH_IDLE;
            PH_RLOW:  if (rlow_end) phase_in = PH_RREL;
            PH_RREL:  if (rrel_end) phase_in = PH_RTAIL;
            PH_RTAIL: if (rtail_end) phase_in = PH_IDLE;
            PH_WRITE: if (wslot_end && last_wbit) phase_in = PH_IDLE;
            PH_READ:  if (rslot_end && last_rbit) phase_in = PH_IDLE;
            default:  phase_in = PH_IDLE;
         endcase
      end
   end

   // Counters, shift registers, flags and the flags of the result word.
   always_comb begin
      slot_in      = slot_ff;
      bit_in       = bit_ff;
      out_shift_in = out_shift_ff;
      in_shift_in  = in_shift_ff;
      presence_in  = presence_ff;
      sign_in      = sign_ff;
      done         = 1'b0;
      rejected     = 1'b0;
      if (is_start) begin
         if (busy) begin
            rejected = 1'b1;
         end else begin
            slot_in = '0;
            bit_in  = '0;
            unique case (item.action)
               ACT_RESET: presence_in = 1'b0;
               ACT_WRITE: out_shift_in = WRITE_BITS'(item.write_byte);
               ACT_READ: begin
                  in_shift_in = '0;
                  sign_in     = 1'b0;
               end
               default: slot_in = '0;
            endcase
         end
      end else if (busy) begin
         slot_in = cnt_inc;
         unique case (phase_ff)
            PH_RLOW: begin
               if (rlow_end) slot_in = '0;
            end
            PH_RREL: begin
               if (rrel_end) begin
                  presence_in = !item.line_level;
                  slot_in     = '0;
               end
            end
            PH_RTAIL: begin
               if (rtail_end) begin
                  slot_in = '0;
                  done    = 1'b1;
               end
            end
            PH_WRITE: begin
               if (wslot_end) begin
                  slot_in      = '0;
                  out_shift_in = out_shift_ff >> 1;
                  bit_in       = bit_inc;
                  done         = last_wbit;
               end
            end
            PH_READ: begin
               if (rsample && item.line_level) begin
                  for (int i = 0; i < READ_BITS; i++) begin
                     if (bit_ff == BW'(i)) in_shift_in[i] = 1'b1;
                  end
                  if (int'(bit_ff) == SIGN_BIT) sign_in = 1'b1;
               end
               if (rslot_end) begin
                  slot_in = '0;
                  bit_in  = bit_inc;
                  done    = last_rbit;
               end
            end
            default: slot_in = '0;
         endcase
      end
   end

   // A start reports the level of its first tick; a tick reports its own level.
   assign drive   = is_start ? drive_level(phase_in, slot_in, out_shift_in[0], timing)
                             : drive_level(phase_ff, slot_ff, out_shift_ff[0], timing);
   assign in_wide = 64'(in_shift_in);

   always_comb begin
      result_in.drive_low = drive;
      result_in.busy_res  = phase_in != PH_IDLE;
      result_in.done_res  = done;
      result_in.presence  = presence_in;
      result_in.read_word = in_wide[15:0];
      result_in.sign_set  = sign_in;
      result_in.rejected  = rejected;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         slot_ff      <= '0;
         bit_ff       <= '0;
         out_shift_ff <= '0;
         in_shift_ff  <= '0;
         presence_ff  <= 1'b0;
         sign_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff     <= phase_in;
            slot_ff      <= slot_in;
            bit_ff       <= bit_in;
            out_shift_ff <= out_shift_in;
            in_shift_ff  <= in_shift_in;
            presence_ff  <= presence_in;
            sign_ff      <= sign_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) result_ff <= result_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

`ifndef SYNTHESIS
   a_reject_keeps_phase: assert property (@(posedge clock) disable iff (reset)
      (fire && is_start && busy) |=> (phase_ff == $past(phase_ff)))
      else $error("rejected start changed the phase");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (fire && done) |=> (phase_ff == PH_IDLE))
      else $error("operation completed without returning to idle");

   a_write_bit_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WRITE) |-> (bit_ff < BW'(WRITE_BITS)))
      else $error("write bit index ran past the last bit");

   a_fire_gives_word: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("accepted word produced no response");
`endif

endmodule

FILE: rtl/core/one_wire_bus_master_unit.sv
// Top level of the one-wire bus master: input register, timing register file
// and sequencer. Depends on owbm_pkg, owbm_req_if, owbm_rsp_if, owbm_csr, owbm_engine.
//
//   channel   direction  handshake                      contents
//   req_chan  in         valid/ready                    action, write_byte, line_level
//   rsp_chan  out        valid/ready                    drive_low, status, read_word
//   csr_*     in         psel/penable/pwrite, pready=1  eight timing registers
//
// Every request word produces exactly one response word. The word passes the input
// register at the edge that accepts it and the result register when the sequencer
// takes it, which waits while a response is held. One word is taken per cycle while
// the response channel is ready, since the phase machine and slot counter are
// updated combinationally between the input and result registers.
// Reset is synchronous and active high; it clears the phase machine, the
// counters, the flags and both valid bits, and loads the default timings.
// When rsp_chan.ready is low the result word holds, the input register fills,
// and req_chan.ready drops until the response is taken.
module one_wire_bus_master_unit #(
   parameter int READ_BITS  = owbm_pkg::READ_BITS_DEFAULT,
   parameter int WRITE_BITS = owbm_pkg::WRITE_BITS_DEFAULT,
   parameter int SIGN_BIT   = owbm_pkg::SIGN_BIT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   owbm_req_if.sink                        req_chan,
   owbm_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [owbm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [owbm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [owbm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import owbm_pkg::*;

   // Input register: one request word waiting for the sequencer.
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       take;
   logic       req_fire;
   timing_type timing;
   result_type result;
   logic       rsp_valid;

   assign req_chan.ready = !in_valid_ff || take;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // A new word loads the register; otherwise a word the sequencer takes leaves it.
   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.action     <= act_type'(req_chan.action);
         in_item_ff.write_byte <= req_chan.write_byte;
         in_item_ff.line_level <= req_chan.line_level;
      end
   end

   owbm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .timing      (timing)
   );

   owbm_engine #(
      .READ_BITS  (READ_BITS),
      .WRITE_BITS (WRITE_BITS),
      .SIGN_BIT   (SIGN_BIT)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .timing     (timing),
      .item_valid (in_valid_ff),
      .item       (in_item_ff),
      .take       (take),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_valid),
      .result     (result)
   );

   // The result register inside the sequencer drives the response channel.
   assign rsp_chan.valid     = rsp_valid;
   assign rsp_chan.drive_low = result.drive_low;
   assign rsp_chan.busy_res  = result.busy_res;
   assign rsp_chan.done_res  = result.done_res;
   assign rsp_chan.presence  = result.presence;
   assign rsp_chan.read_word = result.read_word;
   assign rsp_chan.sign_set  = result.sign_set;
   assign rsp_chan.rejected  = result.rejected;

endmodule
